// ===== sv/afrc_pkg.sv =====
// Shared constants, register indexes and interface types of the audio format and rate converter.
`timescale 1ns / 1ps
`default_nettype none

package afrc_pkg;

    localparam int IDX_W  = 3;
    localparam int CFG_W  = 22;
    localparam int GAIN_W = 20;
    localparam int STEP_W = 22;

    localparam logic [IDX_W-1:0] REG_SOURCE_FORMAT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_STEREO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_Q10        = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_RATIO_Q16  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_SIXTEEN_BIT = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_STEREO      = 3'd5;

    // Source word encodings; unsigned 8-bit is the default for every other code.
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 20'd1024000;

    localparam logic [1:0]        RST_SOURCE_FORMAT = FMT_S16;
    localparam logic [GAIN_W-1:0] RST_GAIN_Q10      = 20'd1024;
    localparam logic [STEP_W-1:0] RST_STEP_RATIO    = 22'd65536;

    localparam int DEF_PHASE_FRAC_BITS = 16;
    localparam int DEF_MAX_REPEAT      = 8;

    typedef struct packed {
        logic [1:0]        source_format;
        logic [GAIN_W-1:0] gain;
        logic              out_sixteen_bit;
    } lane_cfg_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              out_stereo;
    } merge_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] bits;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== sv/afrc_lane.sv =====
// One channel lane: normalizes a raw sample word, applies gain, clamps and formats the output code.
`timescale 1ns / 1ps
`default_nettype none

module afrc_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [31:0]         word,
    input  wire afrc_pkg::lane_cfg_t cfg,
    output afrc_pkg::lane_res_t      res
);
    import afrc_pkg::*;

    localparam int PIPE_N = 5;
    localparam logic signed [44:0] PROD_POS = 45'sd4294967296;
    localparam logic signed [44:0] PROD_NEG = -45'sd4294967296;
    localparam logic signed [33:0] Q32_POS  = 34'sd4294967296;
    localparam logic signed [33:0] Q32_NEG  = -34'sd4294967296;
    localparam logic signed [41:0] U8_BIAS  = 42'sd549755813888;

    logic [PIPE_N-1:0]   vld_reg, vld_next;
    logic [31:0]         word_reg, word_next;
    logic signed [23:0]  q22_reg, q22_next;
    logic                spec_reg, spec_next;
    logic                spec_neg_reg, spec_neg_next;
    logic                spec2_reg, spec2_neg_reg;
    logic signed [44:0]  prod_reg, prod_next;
    logic signed [33:0]  p_reg, p_next;
    logic [15:0]         bits_reg, bits_next;

    logic [7:0]          f_exp, f_exp1, f_rs;
    logic [22:0]         f_frac;
    logic [23:0]         f_man, f_mag;
    logic                f_neg;
    logic signed [48:0]  v_ext, v_scl;
    logic [48:0]         v_rnd;
    logic signed [41:0]  u_ext, u_scl;

    assign vld_next  = {vld_reg[PIPE_N-2:0], start};
    assign word_next = start ? word : word_reg;

    // Stage one: raw word to Q2.22, with infinity and not-a-number flagged.
    always_comb
    begin
        f_exp  = word_reg[30:23];
        f_frac = word_reg[22:0];
        f_neg  = word_reg[31];
        f_man  = {(f_exp != 8'd0), f_frac};
        f_exp1 = (f_exp == 8'd0) ? 8'd1 : f_exp;
        f_rs   = 8'd128 - f_exp1;
        // Any exponent of 2^1 or more overflows Q2.22 and saturates.
        if (f_exp[7])
        begin
            f_mag = f_neg ? 24'h800000 : 24'h7FFFFF;
        end
        else if (f_rs >= 8'd24)
        begin
            f_mag = 24'd0;
        end
        else
        begin
            f_mag = f_man >> f_rs[4:0];
        end

        spec_next     = 1'b0;
        spec_neg_next = 1'b0;
        case (cfg.source_format)
            FMT_S16:
            begin
                q22_next = {word_reg[15], word_reg[15:0], 7'b0};
            end
            FMT_F32:
            begin
                q22_next = f_neg ? (24'd0 - f_mag) : f_mag;
                if (f_exp == 8'hFF)
                begin
                    spec_next     = 1'b1;
                    spec_neg_next = f_neg && (f_frac == 23'd0) && (cfg.gain != '0);
                end
            end
            default:
            begin
                q22_next = {~word_reg[7], ~word_reg[7], word_reg[6:0], 15'b0};
            end
        endcase
    end

    // Stage two: gain multiply.
    assign prod_next = q22_reg * $signed({1'b0, cfg.gain});

    // Stage three: clamp to [-1, 1] in Q32.
    always_comb
    begin
        if (spec2_reg)
        begin
            p_next = spec2_neg_reg ? Q32_NEG : Q32_POS;
        end
        else if (prod_reg > PROD_POS)
        begin
            p_next = Q32_POS;
        end
        else if (prod_reg < PROD_NEG)
        begin
            p_next = Q32_NEG;
        end
        else
        begin
            p_next = prod_reg[33:0];
        end
    end

    // Stage four: scale by 32767 truncating toward zero, or by 127 with offset 128.
    always_comb
    begin
        v_ext = {{15{p_reg[33]}}, p_reg};
        v_scl = (v_ext <<< 15) - v_ext;
        v_rnd = v_scl + (v_scl[48] ? 49'h0_FFFF_FFFF : 49'h0);
        u_ext = {{8{p_reg[33]}}, p_reg};
        u_scl = (u_ext <<< 7) - u_ext + U8_BIAS;
        bits_next = cfg.out_sixteen_bit ? v_rnd[47:32] : {8'b0, u_scl[39:32]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        q22_reg       <= q22_next;
        spec_reg      <= spec_next;
        spec_neg_reg  <= spec_neg_next;
        prod_reg      <= prod_next;
        spec2_reg     <= spec_reg;
        spec2_neg_reg <= spec_neg_reg;
        p_reg         <= p_next;
        bits_reg      <= bits_next;
    end

    assign res.valid = vld_reg[PIPE_N-1];
    assign res.bits  = bits_reg;

endmodule

`default_nettype wire

// ===== sv/afrc_merge.sv =====
// Merge stage: joins the two lane codes into a frame and repeats or drops it by the phase.
`timescale 1ns / 1ps
`default_nettype none

module afrc_merge #(
    parameter int PHASE_FRAC_BITS = afrc_pkg::DEF_PHASE_FRAC_BITS,
    parameter int MAX_REPEAT      = afrc_pkg::DEF_MAX_REPEAT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 block_start,
    input  wire afrc_pkg::lane_res_t  res_l,
    input  wire afrc_pkg::lane_res_t  res_r,
    input  wire afrc_pkg::merge_cfg_t cfg,
    input  wire logic                 out_take,
    output logic                      ready,
    output logic                      out_valid,
    output logic [15:0]               out_left,
    output logic [15:0]               out_right,
    output logic                      out_last
);
    import afrc_pkg::*;

    localparam int PHASE_W = ((PHASE_FRAC_BITS + 1 > STEP_W) ? PHASE_FRAC_BITS + 1 : STEP_W) + 1;
    localparam int CNT_W   = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = {{(PHASE_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
    localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(MAX_REPEAT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               bstart_reg, bstart_next;
    logic               valid_reg, valid_next;
    logic               last_reg, last_next;
    logic [15:0]        left_reg, left_next;
    logic [15:0]        right_reg, right_next;

    logic [PHASE_W-1:0] step_ext, phase_start, phase_add;

    assign step_ext    = PHASE_W'(cfg.step);
    assign phase_start = bstart_reg ? '0 : phase_reg;
    // In the emit state the phase register already holds the value after the current frame.
    assign phase_add   = ((state_reg == ST_EMIT) ? phase_reg : phase_start) + step_ext;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        bstart_next = bstart_reg;
        valid_next  = valid_reg;
        last_next   = last_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bstart_next = block_start;
                    state_next  = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (res_l.valid)
                begin
                    left_next  = res_l.bits;
                    right_next = cfg.out_stereo ? res_r.bits : 16'd0;
                    if (phase_start >= PHASE_ONE)
                    begin
                        // Frame is dropped: no result for this item.
                        phase_next = phase_start - PHASE_ONE;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_add;
                        cnt_next   = '0;
                        valid_next = 1'b1;
                        last_next  = (phase_add >= PHASE_ONE) || (LAST_CNT == '0);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_valid && out_take)
                begin
                    if (last_reg)
                    begin
                        // A capped run that leaves the phase short of one restarts at zero.
                        phase_next = (phase_reg >= PHASE_ONE) ? phase_reg - PHASE_ONE : '0;
                        valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_add;
                        cnt_next   = cnt_reg + 1'b1;
                        last_next  = (phase_add >= PHASE_ONE) || (cnt_reg + 1'b1 == LAST_CNT);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bstart_reg <= bstart_next;
        last_reg   <= last_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== sv/audio_format_resample_convert_unit.sv =====
// Top level of the audio format and rate converter: registers, two lanes and the merge stage.
// Each item passes the five-stage conversion lane (word, Q2.22, gain product, clamp, output code) and
// then the merge output register. One item at a time: a new item is accepted only after the last result
// of the previous one is taken. An item yields n results (0 to MAX_REPEAT), one result per cycle at the
// output register while the receiver takes them; a stalled output holds the flow.
// Reset clears the configuration registers to their defaults and the phase to zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module audio_format_resample_convert_unit #(
    parameter int PHASE_FRAC_BITS = afrc_pkg::DEF_PHASE_FRAC_BITS,
    parameter int MAX_REPEAT      = afrc_pkg::DEF_MAX_REPEAT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [afrc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [afrc_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [63:0]                s_tdata,  // src_left [31:0], src_right [63:32]
    input  wire logic                       s_tuser,  // block_start
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [31:0]                     m_tdata,  // out_left [15:0], out_right [31:16]
    output logic                            m_tlast
);
    import afrc_pkg::*;

    logic [1:0]        source_format_reg, source_format_next;
    logic              source_stereo_reg, source_stereo_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_sixteen_reg, out_sixteen_next;
    logic              out_stereo_reg, out_stereo_next;

    logic       accept;
    lane_cfg_t  lane_cfg;
    merge_cfg_t merge_cfg;
    lane_res_t  res_l, res_r;
    logic [31:0] right_word;
    logic [15:0] out_left, out_right;

    always_comb
    begin
        source_format_next = source_format_reg;
        source_stereo_next = source_stereo_reg;
        gain_next          = gain_reg;
        step_next          = step_reg;
        out_sixteen_next   = out_sixteen_reg;
        out_stereo_next    = out_stereo_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT:   source_format_next = cfg_wdata[1:0];
                REG_SOURCE_STEREO:   source_stereo_next = cfg_wdata[0];
                REG_GAIN_Q10:        gain_next          = cfg_wdata[GAIN_W-1:0];
                REG_STEP_RATIO_Q16:  step_next          = cfg_wdata[STEP_W-1:0];
                REG_OUT_SIXTEEN_BIT: out_sixteen_next   = cfg_wdata[0];
                REG_OUT_STEREO:      out_stereo_next    = cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= RST_SOURCE_FORMAT;
            source_stereo_reg <= 1'b1;
            gain_reg          <= RST_GAIN_Q10;
            step_reg          <= RST_STEP_RATIO;
            out_sixteen_reg   <= 1'b0;
            out_stereo_reg    <= 1'b0;
        end
        else
        begin
            source_format_reg <= source_format_next;
            source_stereo_reg <= source_stereo_next;
            gain_reg          <= gain_next;
            step_reg          <= step_next;
            out_sixteen_reg   <= out_sixteen_next;
            out_stereo_reg    <= out_stereo_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    // Gain saturates at 1000; a zero step counts as one LSB.
    assign lane_cfg.source_format   = source_format_reg;
    assign lane_cfg.gain            = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign lane_cfg.out_sixteen_bit = out_sixteen_reg;
    assign merge_cfg.step           = (step_reg == '0) ? {{(STEP_W-1){1'b0}}, 1'b1} : step_reg;
    assign merge_cfg.out_stereo     = out_stereo_reg;

    // A mono source feeds the left word to both lanes.
    assign right_word = source_stereo_reg ? s_tdata[63:32] : s_tdata[31:0];

    afrc_lane u_lane_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .word  (s_tdata[31:0]),
        .cfg   (lane_cfg),
        .res   (res_l)
    );

    afrc_lane u_lane_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .word  (right_word),
        .cfg   (lane_cfg),
        .res   (res_r)
    );

    afrc_merge #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .MAX_REPEAT      (MAX_REPEAT)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .block_start (s_tuser),
        .res_l       (res_l),
        .res_r       (res_r),
        .cfg         (merge_cfg),
        .out_take    (m_tready),
        .ready       (s_tready),
        .out_valid   (m_tvalid),
        .out_left    (out_left),
        .out_right   (out_right),
        .out_last    (m_tlast)
    );

    assign m_tdata = {out_right, out_left};

endmodule

`default_nettype wire

// ===== tb/afrc_result_checker.sv =====
// Watches the converter's channels, predicts every output frame and compares it with the block.
`timescale 1ns / 1ps

module afrc_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [afrc_pkg::IDX_W-1:0] cfg_index,
    input  logic [afrc_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [63:0]                s_tdata,   // src_left [31:0], src_right [63:32]
    input  logic                       s_tuser,   // block_start
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata,   // out_left [15:0], out_right [31:16]
    input  logic                       m_tlast,
    output int                         mismatches,
    output int                         outstanding
);
    import afrc_pkg::*;

    localparam logic [63:0]        PHASE_ONE = 64'd1 << DEF_PHASE_FRAC_BITS;
    localparam logic signed [63:0] Q32_ONE   = 64'sh1_0000_0000;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_right;
        logic        last_of_run;
    } frame_t;

    frame_t expected_frames[$];
    frame_t got_frame;
    int     err_count;

    // Shadow copy of the block's registers and phase accumulator.
    logic [1:0]        src_format;
    logic              src_stereo;
    logic [GAIN_W-1:0] gain_q10;
    logic [STEP_W-1:0] step_ratio;
    logic              out_sixteen;
    logic              out_stereo;
    logic [63:0]       phase_acc;

    // Normalizes a raw word to Q2.22, applies the gain and clamps the product to +-1 in Q32.
    function automatic logic signed [63:0] gained_level(input logic [31:0] w);
        logic signed [63:0] q22;
        logic signed [63:0] prod;
        logic [GAIN_W-1:0]  g;
        logic [7:0]         e;
        logic [22:0]        frac;
        logic               neg;
        logic [63:0]        lim;
        logic [63:0]        m;
        logic [63:0]        mag;
        int                 sh;
        g = (gain_q10 > GAIN_MAX) ? GAIN_MAX : gain_q10;
        if (src_format == FMT_S16)
        begin
            q22 = {{48{w[15]}}, w[15:0]};
            q22 = q22 * 128;
        end
        else if (src_format == FMT_F32)
        begin
            e    = w[30:23];
            frac = w[22:0];
            neg  = w[31];
            lim  = neg ? (64'd1 << 23) : ((64'd1 << 23) - 64'd1);
            if (e == 8'hFF)
            begin
                // Not-a-number, and infinity under zero gain, both come out as full scale.
                if (frac != 23'd0 || g == '0)
                    return Q32_ONE;
                return neg ? -Q32_ONE : Q32_ONE;
            end
            m  = (e == 8'd0) ? {41'd0, frac} : {40'd0, 1'b1, frac};
            sh = ((e == 8'd0) ? 1 : int'(e)) - 128;
            if (m == 64'd0)
                mag = 64'd0;
            else if (sh >= 0)
            begin
                if (sh >= 24)
                    mag = lim;
                else
                    mag = m << sh;
            end
            else
                mag = (-sh >= 32) ? 64'd0 : (m >> (-sh));
            if (mag > lim)
                mag = lim;
            q22 = neg ? -$signed(mag) : $signed(mag);
        end
        else
        begin
            q22 = $signed({56'd0, w[7:0]}) - 64'sd128;
            q22 = q22 * 32768;
        end
        prod = q22 * $signed({44'd0, g});
        if (prod > Q32_ONE)
            prod = Q32_ONE;
        if (prod < -Q32_ONE)
            prod = -Q32_ONE;
        return prod;
    endfunction

    function automatic logic [15:0] output_code(input logic signed [63:0] p);
        logic signed [63:0] v;
        logic signed [63:0] t;
        logic [63:0]        u;
        if (out_sixteen)
        begin
            // Signed output truncates toward zero, so the magnitude is shifted.
            v = p * 32767;
            t = (v >= 0) ? (v >>> 32) : -((-v) >>> 32);
            return t[15:0];
        end
        u = p * 127 + (64'sd128 <<< 32);
        return {8'd0, u[39:32]};
    endfunction

    task automatic predict_frames(input logic [31:0] lw, input logic [31:0] rw,
                                  input logic start);
        logic signed [63:0] lq;
        logic signed [63:0] rq;
        logic [63:0]        step;
        frame_t             f;
        int                 n;
        step = (step_ratio == '0) ? 64'd1 : 64'(step_ratio);
        lq   = gained_level(lw);
        rq   = src_stereo ? gained_level(rw) : lq;
        f.out_left  = output_code(lq);
        f.out_right = out_stereo ? output_code(rq) : 16'd0;
        if (start)
            phase_acc = 64'd0;
        n = 0;
        while (phase_acc < PHASE_ONE && n < DEF_MAX_REPEAT)
        begin
            f.last_of_run = (phase_acc + step >= PHASE_ONE) || (n == DEF_MAX_REPEAT - 1);
            expected_frames.insert(expected_frames.size(), f);
            n++;
            phase_acc += step;
        end
        // When the repeat cap stops the run early the phase restarts at zero.
        phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : 64'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_format  = RST_SOURCE_FORMAT;
            src_stereo  = 1'b1;
            gain_q10    = RST_GAIN_Q10;
            step_ratio  = RST_STEP_RATIO;
            out_sixteen = 1'b0;
            out_stereo  = 1'b0;
            phase_acc   = 64'd0;
            err_count   = 0;
            expected_frames.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_FORMAT:   src_format  = cfg_wdata[1:0];
                    REG_SOURCE_STEREO:   src_stereo  = cfg_wdata[0];
                    REG_GAIN_Q10:        gain_q10    = cfg_wdata[GAIN_W-1:0];
                    REG_STEP_RATIO_Q16:  step_ratio  = cfg_wdata[STEP_W-1:0];
                    REG_OUT_SIXTEEN_BIT: out_sixteen = cfg_wdata[0];
                    REG_OUT_STEREO:      out_stereo  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_frames(s_tdata[31:0], s_tdata[63:32], s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected output item: out_left %h out_right %h last_of_run %b",
                           m_tdata[15:0], m_tdata[31:16], m_tlast);
                    err_count++;
                end
                else
                begin
                    got_frame = expected_frames.pop_front();
                    if (m_tdata[15:0] !== got_frame.out_left)
                    begin
                        $error("out_left: expected %h, actual %h",
                               got_frame.out_left, m_tdata[15:0]);
                        err_count++;
                    end
                    if (m_tdata[31:16] !== got_frame.out_right)
                    begin
                        $error("out_right: expected %h, actual %h",
                               got_frame.out_right, m_tdata[31:16]);
                        err_count++;
                    end
                    if (m_tlast !== got_frame.last_of_run)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               got_frame.last_of_run, m_tlast);
                        err_count++;
                    end
                end
            end
            mismatches  <= err_count;
            outstanding <= expected_frames.size();
        end
    end

endmodule

// ===== tb/audio_format_resample_convert_unit_tb.sv =====
// Stimulus, receiver stalls and final verdict for the audio format and rate converter.
`timescale 1ns / 1ps

module audio_format_resample_convert_unit_tb;
    import afrc_pkg::*;

    localparam int RUN_LIMIT_NS = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 34;

    localparam logic [1:0]       FMT_U8       = 2'd0;
    localparam logic [1:0]       FMT_UNUSED   = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam logic [CFG_W-1:0] STEP_MIN = 22'd8192;
    localparam logic [CFG_W-1:0] STEP_MAX = 22'd3145728;

    localparam logic [31:0] F32_QNAN    = 32'h7FC0_0001;
    localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
    localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [63:0]      s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;
    logic             m_tlast;
    int               mismatches;
    int               outstanding;

    bit rx_idle_en;
    bit tx_idle_en;
    bit hold_req;

    audio_format_resample_convert_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    afrc_result_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(input logic [1:0] fmt, input logic src_st,
                                 input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] step,
                                 input logic o16, input logic o_st);
        write_reg(REG_SOURCE_FORMAT, CFG_W'(fmt));
        write_reg(REG_SOURCE_STEREO, CFG_W'(src_st));
        write_reg(REG_GAIN_Q10, gain);
        write_reg(REG_STEP_RATIO_Q16, step);
        write_reg(REG_OUT_SIXTEEN_BIT, CFG_W'(o16));
        write_reg(REG_OUT_STEREO, CFG_W'(o_st));
    endtask

    task automatic send_frame(input logic [31:0] lw, input logic [31:0] rw, input logic start);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rw, lw};
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering items and waits until every predicted frame has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(input logic [1:0] fmt);
        logic [7:0] e;
        if (fmt != FMT_F32)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       e = 8'hFF;
            1:       e = 8'h00;
            2:       e = 8'($urandom);
            default: e = 8'($urandom_range(100, 135));
        endcase
        return {1'($urandom), e, 23'($urandom)};
    endfunction

    // Receiver: random stall bursts, plus one long hold-off when asked for.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [1:0]       fmt;
        logic [CFG_W-1:0] gain;
        logic [CFG_W-1:0] step;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        hold_req   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: signed 16-bit stereo source, unity gain and rate, u8 mono output.
        send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b1);
        send_frame(32'h0000_8000, 32'h0000_7FFF, 1'b0);
        send_frame(32'hFFFF_0000, 32'h0000_0000, 1'b0);
        settle();

        // Mono u8 source, gain above the ceiling and zero step, so every item hits the cap.
        load_settings(FMT_U8, 1'b0, 22'h3FFFFF, 22'd0, 1'b1, 1'b1);
        write_reg(REG_UNMAPPED, 22'h155555);
        send_frame(32'h0000_00FF, 32'h0000_0000, 1'b1);
        send_frame(32'h0000_0000, 32'h0000_00FF, 1'b0);
        send_frame(32'h0000_0080, 32'h0000_007F, 1'b0);
        settle();

        // Float source at the fastest decimation; block starts force one frame per item.
        load_settings(FMT_F32, 1'b1, RST_GAIN_Q10, STEP_MAX, 1'b1, 1'b1);
        send_frame(F32_QNAN, F32_POS_INF, 1'b1);
        send_frame(F32_NEG_INF, F32_QNAN, 1'b1);
        send_frame(32'h0000_0001, 32'h7F7F_FFFF, 1'b1);
        send_frame(32'hFF7F_FFFF, 32'h8000_0000, 1'b1);
        send_frame(32'hBFC0_0000, 32'h3F00_0000, 1'b1);
        send_frame(32'h3F00_0000, 32'hBF00_0000, 1'b1);
        send_frame(32'h0080_0000, 32'h4B00_0000, 1'b1);
        send_frame(32'h3FFF_FFFF, 32'hC000_0000, 1'b1);
        settle();

        // Infinity under zero gain at the slowest step.
        load_settings(FMT_F32, 1'b1, 22'd0, STEP_MIN, 1'b0, 1'b1);
        send_frame(F32_POS_INF, F32_NEG_INF, 1'b1);
        send_frame(F32_NEG_INF, F32_POS_INF, 1'b0);
        send_frame(F32_QNAN, 32'h3F80_0000, 1'b0);
        settle();

        // The spare format code decodes as u8.
        load_settings(FMT_UNUSED, 1'b0, 22'd512, 22'd98304, 1'b0, 1'b0);
        send_frame(32'h0000_00AB, 32'h0000_0001, 1'b1);
        send_frame(32'h0000_0001, 32'h0000_00FE, 1'b0);
        send_frame(32'h0000_00FE, 32'h0000_00AB, 1'b0);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            fmt = (ph < 3) ? 2'(ph) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       gain = CFG_W'(GAIN_MAX);
                1:       gain = CFG_W'($urandom_range(0, 1024000));
                2:       gain = CFG_W'($urandom_range(0, 2048));
                3:       gain = 22'h3FFFFF;
                default: gain = 22'd0;
            endcase
            if (ph == 0)
                step = STEP_MIN;
            else if (ph == 1)
                step = STEP_MAX;
            else
            begin
                case ($urandom_range(0, 5))
                    0:       step = CFG_W'($urandom_range(STEP_MIN, STEP_MAX));
                    1:       step = 22'd0;
                    2:       step = 22'h3FFFFF;
                    default: step = CFG_W'($urandom_range(16384, 131072));
                endcase
            end
            load_settings(fmt, 1'($urandom), gain, step, 1'($urandom), 1'($urandom));
            // The last phase runs at full rate on both sides.
            rx_idle_en = (ph != 5) && ($urandom_range(0, 3) != 0);
            tx_idle_en = (ph != 5) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == 5)
                    hold_req = 1'b1;
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    settle();
                send_frame(rand_word(fmt), rand_word(fmt), $urandom_range(0, 3) == 0);
            end
            settle();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
